// ===== design/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared widths, codes, character constants, state types and helper
// functions for the integer to ASCII digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned NIB_W     = 4;
    // 2^32 - 1 has ten decimal digits; hex needs eight nibbles of the ten
    localparam int unsigned DIGITS    = 10;
    localparam int unsigned DIG_W     = DIGITS * NIB_W;
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
    localparam int unsigned LEFT_W    = $clog2(DIGITS + 1);

    // Mode codes: signed decimal; op bit 1 selects base 16 (codes 2 and 3)
    localparam logic [OP_W-1:0] OP_SDEC       = 2'd0;
    localparam int unsigned     OP_BASE16_BIT = 1;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_A_LOW = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2d;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_DONE
    } t_conv_state;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_SIGN,
        EM_DIGIT
    } t_emit_state;

    // Digit word passed from the converter to the character emitter
    typedef struct packed {
        logic [DIG_W-1:0] digits;
        logic             neg;
    } t_digits;

    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [NIB_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < NIB_W'(10)) begin
            c = CHR_ZERO + CHAR_W'(d);
        end else begin
            c = CHR_A_LOW + CHAR_W'(d - NIB_W'(10));
        end
        return c;
    endfunction

    // Shift-and-add-3 correction of one BCD digit
    function automatic logic [NIB_W-1:0] f_bcd_adjust(input logic [NIB_W-1:0] d);
        logic [NIB_W-1:0] a;
        if (d >= NIB_W'(5)) begin
            a = d + NIB_W'(3);
        end else begin
            a = d;
        end
        return a;
    endfunction

    function automatic logic f_is_bcd(input logic [DIG_W-1:0] w);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (w[i*NIB_W +: NIB_W] > NIB_W'(9)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/i2a_if.sv =====
// ----------------------------------------------------------------------------
// i2a_if
// Valid/ready channel interfaces for the number input and the character
// output of the integer to ASCII digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_in_if;
    logic                       valid;
    logic                       ready;
    logic [i2a_pkg::VALUE_W-1:0] value;
    logic [i2a_pkg::OP_W-1:0]    op;

    modport source (output valid, output value, output op, input ready);
    modport sink   (input valid, input value, input op, output ready);
endinterface

interface i2a_out_if;
    logic                        valid;
    logic                        ready;
    logic [i2a_pkg::CHAR_W-1:0]  out_char;
    logic                        last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

// ===== design/integer_to_ascii_digits_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core
// Converts a 32-bit word to ASCII text (signed decimal, unsigned decimal or
// lowercase hex), one character per output transaction, last one marked.
//
//   Channel  Dir  Payload           Accepted when
//   i_in     in   value[31:0], op   i_in.valid && i_in.ready
//   o_out    out  out_char[7:0],    o_out.valid && o_out.ready
//                 last
//
// Decimal: the word is loaded, then all 32 magnitude bits are shifted through
// the BCD shift register, one bit per cycle, and the digits are handed off.
// Hex skips the shift loop. The emitter then drops each leading zero nibble
// (up to 9), picks the sign or the first digit, and sends each character
// (1 to 11) while o_out is not stalled. Conversion of the next number
// overlaps emission of the current one.
// Reset is synchronous, active low, and empties both stages.
// A stalled o_out holds the output register and pauses the emitter before its next character.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_digits_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2a_in_if.sink    i_in,
    i2a_out_if.source o_out
);
    import i2a_pkg::*;

    logic    w_dig_valid;
    logic    w_dig_ready;
    t_digits w_dig;

    i2a_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_dig_valid (w_dig_valid),
        .i_dig_ready (w_dig_ready),
        .o_dig       (w_dig)
    );

    i2a_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dig_valid (w_dig_valid),
        .o_dig_ready (w_dig_ready),
        .i_dig       (w_dig),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== design/i2a_conv.sv =====
// ----------------------------------------------------------------------------
// i2a_conv
// Bit-serial binary to digit converter: takes the magnitude of the input
// word and builds ten BCD digits by shift-and-add-3, one bit per cycle.
// Hex words are loaded as nibbles directly.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2a_in_if.sink            i_in,
    output logic              o_dig_valid,
    input  logic              i_dig_ready,
    output i2a_pkg::t_digits  o_dig
);
    import i2a_pkg::*;

    t_conv_state            r_state, n_state;
    logic [VALUE_W-1:0]     r_bin;
    logic [DIG_W-1:0]       r_bcd;
    logic [DIG_W-1:0]       w_adj;
    logic [BIT_CNT_W-1:0]   r_cnt;
    logic                   r_neg;
    logic                   r_hex;
    logic                   w_take;
    logic                   w_neg;
    logic                   w_hex;
    logic [VALUE_W-1:0]     w_mag;

    assign w_take = i_in.valid && i_in.ready;
    assign w_hex  = i_in.op[OP_BASE16_BIT];
    assign w_neg  = (i_in.op == OP_SDEC) && i_in.value[VALUE_W-1];
    // two's complement magnitude; the most negative value maps onto itself
    assign w_mag  = w_neg ? VALUE_W'(~i_in.value + 1'b1) : i_in.value;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_adj[i*NIB_W +: NIB_W] = f_bcd_adjust(r_bcd[i*NIB_W +: NIB_W]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CV_IDLE: begin
                if (w_take) begin
                    n_state = w_hex ? CV_DONE : CV_SHIFT;
                end
            end
            CV_SHIFT: begin
                if (r_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                    n_state = CV_DONE;
                end
            end
            CV_DONE: begin
                if (i_dig_ready) begin
                    n_state = CV_IDLE;
                end
            end
            default: n_state = CV_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready   = (r_state == CV_IDLE);
        o_dig_valid  = (r_state == CV_DONE);
        o_dig.digits = r_bcd;
        o_dig.neg    = r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_bin <= w_mag;
            r_bcd <= w_hex ? DIG_W'(i_in.value) : '0;
            r_cnt <= '0;
            r_neg <= w_neg;
            r_hex <= w_hex;
        end else if (r_state == CV_SHIFT) begin
            // correct, then shift the next magnitude bit in at the bottom
            r_bcd <= {w_adj[DIG_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    a_bcd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CV_DONE && !r_hex) |-> f_is_bcd(r_bcd))
        else $error("decimal digit word holds a nibble above nine");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state != CV_IDLE))
        else $error("converter idle right after taking a transaction");

    a_shift_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CV_SHIFT) |-> !r_hex)
        else $error("hex word entered the decimal shift loop");

endmodule

`default_nettype wire

// ===== design/i2a_emit.sv =====
// ----------------------------------------------------------------------------
// i2a_emit
// Character emitter: drops leading zero nibbles one per cycle, then sends
// the sign and the digits most significant first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_dig_valid,
    output logic              o_dig_ready,
    input  i2a_pkg::t_digits  i_dig,
    i2a_out_if.source         o_out
);
    import i2a_pkg::*;

    t_emit_state            r_state, n_state;
    logic [DIG_W-1:0]       r_dig;
    logic [LEFT_W-1:0]      r_left;
    logic                   r_neg;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;
    logic                   r_ovalid;
    logic                   w_free;
    logic                   w_load;
    logic                   w_skip;
    logic                   w_shift;
    logic                   w_put_sign;
    logic                   w_put_dig;
    logic [NIB_W-1:0]       w_top;

    assign w_free = !r_ovalid || o_out.ready;
    assign w_load = i_dig_valid && o_dig_ready;
    assign w_top  = r_dig[DIG_W-1 -: NIB_W];
    // keep at least one digit so that zero prints as '0'
    assign w_skip = (w_top == '0) && (r_left != LEFT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EM_IDLE: begin
                if (i_dig_valid) begin
                    n_state = EM_SKIP;
                end
            end
            EM_SKIP: begin
                if (!w_skip) begin
                    n_state = r_neg ? EM_SIGN : EM_DIGIT;
                end
            end
            EM_SIGN: begin
                if (w_free) begin
                    n_state = EM_DIGIT;
                end
            end
            EM_DIGIT: begin
                if (w_free && r_left == LEFT_W'(1)) begin
                    n_state = EM_IDLE;
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_comb begin
        o_dig_ready = (r_state == EM_IDLE);
        w_put_sign  = (r_state == EM_SIGN) && w_free;
        w_put_dig   = (r_state == EM_DIGIT) && w_free;
        w_shift     = ((r_state == EM_SKIP) && w_skip) || w_put_dig;
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_char = r_char;
    assign o_out.last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= EM_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_put_sign || w_put_dig) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dig  <= i_dig.digits;
            r_left <= LEFT_W'(DIGITS);
            r_neg  <= i_dig.neg;
        end else if (w_shift) begin
            r_dig  <= {r_dig[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
            r_left <= r_left - 1'b1;
        end
        if (w_put_sign) begin
            r_char <= CHR_MINUS;
            r_last <= 1'b0;
        end else if (w_put_dig) begin
            r_char <= f_digit_char(w_top);
            r_last <= (r_left == LEFT_W'(1));
        end
    end

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != EM_IDLE) |-> (r_left != '0))
        else $error("emitter busy with no digits left");

    a_load_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == EM_SKIP))
        else $error("loaded digit word did not start the zero skip");

    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == EM_SIGN) |-> r_neg)
        else $error("sign emitted for a non-negative number");

endmodule

`default_nettype wire

// ===== tb/sv/tb_integer_to_ascii_digits_core.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits_core
// Self-checking bench for the integer to ASCII converter: a directed set of
// edge values in every mode, then random numbers in four idle/stall phases,
// each character checked against text predicted from the accepted number.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_integer_to_ascii_digits_core;

    import i2a_pkg::*;

    localparam logic [OP_W-1:0] OP_UDEC     = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX      = 2'd2;
    localparam logic [OP_W-1:0] OP_HEX_ALT  = 2'd3;
    localparam int unsigned     RAND_ITEMS  = 370;
    localparam int unsigned     DRAIN_CYC   = 64;
    localparam int unsigned     CYCLE_LIMIT = 400000;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    class text_scoreboard;
        t_text_char  text_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            if (errors < 40) begin
                $display("mismatch @%0t: %s", $time, msg);
            end
            errors++;
        endtask

        // Build the text of one accepted number and append it
        function void note_number(input logic [VALUE_W-1:0] value, input logic [OP_W-1:0] op);
            logic [VALUE_W-1:0] mag;
            logic [NIB_W-1:0]   dig;
            logic [CHAR_W-1:0]  rev[$];
            logic               neg;
            logic               base16;
            t_text_char         tc;
            base16 = op[OP_BASE16_BIT];
            neg    = (op == OP_SDEC) && value[VALUE_W-1];
            mag    = neg ? (VALUE_W'(0) - value) : value;
            if (mag == '0) begin
                rev.push_back(CHR_ZERO);
            end
            while (mag != '0) begin
                if (base16) begin
                    dig = mag[NIB_W-1:0];
                    mag = mag >> NIB_W;
                end else begin
                    dig = NIB_W'(mag % 10);
                    mag = mag / 10;
                end
                if (dig < 4'd10) begin
                    rev.push_back(CHR_ZERO + CHAR_W'(dig));
                end else begin
                    rev.push_back(CHR_A_LOW + CHAR_W'(dig) - 8'd10);
                end
            end
            if (neg) begin
                rev.push_back(CHR_MINUS);
            end
            for (int k = rev.size() - 1; k >= 0; k--) begin
                tc.ch   = rev[k];
                tc.last = (k == 0);
                text_q.push_back(tc);
            end
        endfunction

        task check_char(input logic [CHAR_W-1:0] ch, input logic last);
            t_text_char tc;
            if (text_q.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
            end else begin
                tc = text_q.pop_front();
                if (ch !== tc.ch) begin
                    report($sformatf("char 0x%02h, want 0x%02h", ch, tc.ch));
                end
                if (last !== tc.last) begin
                    report($sformatf("last %0b, want %0b (char 0x%02h)", last, tc.last, tc.ch));
                end
            end
        endtask

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned cycles;
    text_scoreboard sb;

    i2a_in_if  in_if ();
    i2a_out_if out_if ();

    integer_to_ascii_digits_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Random backpressure on the character channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor both channels at the edge where a transaction completes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_number(in_if.value, in_if.op);
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_char(out_if.out_char, out_if.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars outstanding", cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold the number on the channel until it is taken; idle first at random
    task send_number(input logic [VALUE_W-1:0] value, input logic [OP_W-1:0] op);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 20) begin
            gap++;
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        in_if.op    <= op;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] p;
        int unsigned k;
        p = 1;
        case ($urandom_range(0, 6))
            0, 1: return $urandom;
            2: return VALUE_W'($urandom_range(0, 20));
            3: return VALUE_W'(0) - VALUE_W'($urandom_range(1, 20));
            4: begin
                // around a power of ten
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
                return p + VALUE_W'($urandom_range(0, 2)) - 1;
            end
            5: begin
                // around a nibble boundary
                k = $urandom_range(1, 7);
                return (p << (NIB_W * k)) + VALUE_W'($urandom_range(0, 2)) - 1;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return OP_SDEC;
        if (r < 6) return OP_UDEC;
        if (r < 9) return OP_HEX;
        return OP_HEX_ALT;
    endfunction

    initial begin
        logic [VALUE_W-1:0] dir_val[$];
        logic [OP_W-1:0]    dir_op[$];
        sb = new();
        idle_pct     = 0;
        stall_pct    = 0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.op     = OP_SDEC;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero in every mode, all-ones, the most negative value, boundaries
        dir_val = {32'h0, 32'h0, 32'h0, 32'h0,
                   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h1, 32'h9, 32'ha, 32'd1000000000,
                   32'habcd_ef01, 32'hf, 32'h10, 32'd4294967295, 32'h8000_0001};
        dir_op  = {OP_SDEC, OP_UDEC, OP_HEX, OP_HEX_ALT,
                   OP_SDEC, OP_UDEC, OP_HEX, OP_HEX_ALT,
                   OP_SDEC, OP_UDEC, OP_HEX,
                   OP_SDEC, OP_SDEC, OP_UDEC, OP_UDEC, OP_UDEC,
                   OP_HEX_ALT, OP_HEX, OP_HEX, OP_UDEC, OP_SDEC};
        foreach (dir_val[i]) begin
            send_number(dir_val[i], dir_op[i]);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            repeat (RAND_ITEMS / 4) send_number(pick_value(), pick_op());
        end
        in_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
